// File: hdl/tcg_pkg.sv
// shared types and constants for the transport checksum generator
`timescale 1ns / 1ps
`default_nettype none

package tcg_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_DATA  = 1'b1;

	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam logic [7:0] PROTO_TCP = 8'd6;

	localparam logic [14:0] UDP_CK_WORD = 15'd3;
	localparam logic [14:0] TCP_CK_WORD = 15'd8;
	localparam logic [14:0] INDEX_MAX   = 15'h7fff;

	localparam logic [1:0] BCNT_ONE = 2'd1;

	localparam logic [15:0] SUM_ALL_ONES = 16'hffff;

	// one classified word between front and back
	typedef struct packed {
		logic        start;
		logic        last;
		logic        err;
		logic [15:0] value;
	} tcg_entry_t;

endpackage

`default_nettype wire

// File: hdl/tcg_front.sv
// front end: classifies words, folds the pseudo-header, masks checksum field
`timescale 1ns / 1ps
`default_nettype none

module tcg_front
	import tcg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [31:0] src_addr,
	input  wire logic [31:0] dst_addr,
	input  wire logic [7:0]  protocol,
	input  wire logic [15:0] seg_length,
	input  wire logic [15:0] data_word,
	input  wire logic [1:0]  byte_count,
	input  wire logic        last,
	input  wire logic        q_full,
	output logic             push,
	output tcg_entry_t       entry
);

	typedef enum logic [1:0] {
		SEL_NONE = 2'd0,
		SEL_UDP  = 2'd1,
		SEL_TCP  = 2'd2
	} sel_t;

	sel_t        proto_sel_q;
	logic [14:0] word_index_q;

	logic [18:0] ph_total;
	logic [16:0] ph_fold1;
	logic [15:0] ph_sum;
	logic [15:0] dw;
	logic [14:0] ck_pos;
	sel_t        new_sel;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		ph_total = {3'b0, src_addr[31:16]} + {3'b0, src_addr[15:0]}
			+ {3'b0, dst_addr[31:16]} + {3'b0, dst_addr[15:0]}
			+ {11'b0, protocol} + {3'b0, seg_length};
		// end-around carry, twice to absorb the carry of the first fold
		ph_fold1 = {1'b0, ph_total[15:0]} + {14'b0, ph_total[18:16]};
		ph_sum   = ph_fold1[15:0] + {15'b0, ph_fold1[16]};

		if (protocol == PROTO_UDP)
			new_sel = SEL_UDP;
		else if (protocol == PROTO_TCP)
			new_sel = SEL_TCP;
		else
			new_sel = SEL_NONE;

		dw = (byte_count == BCNT_ONE) ? {data_word[15:8], 8'h00} : data_word;
		ck_pos = (proto_sel_q == SEL_TCP) ? TCP_CK_WORD : UDP_CK_WORD;
		if (proto_sel_q != SEL_NONE && word_index_q == ck_pos)
			dw = '0;

		if (kind == KIND_START) begin
			entry.start = 1'b1;
			entry.last  = 1'b0;
			entry.err   = 1'b0;
			entry.value = ph_sum;
		end else begin
			entry.start = 1'b0;
			entry.last  = last;
			entry.err   = (proto_sel_q == SEL_NONE);
			entry.value = dw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proto_sel_q  <= SEL_NONE;
			word_index_q <= '0;
		end else if (push) begin
			if (kind == KIND_START) begin
				proto_sel_q  <= new_sel;
				word_index_q <= '0;
			end else if (last) begin
				proto_sel_q  <= SEL_NONE;
				word_index_q <= '0;
			end else if (word_index_q != INDEX_MAX) begin
				word_index_q <= word_index_q + 15'd1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/tcg_queue.sv
// short word queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module tcg_queue
	import tcg_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire tcg_entry_t wr_entry,
	output logic            full,
	input  wire logic       pop,
	output tcg_entry_t      rd_entry,
	output logic            empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	tcg_entry_t    mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue read while empty");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count out of range");

endmodule

`default_nettype wire

// File: hdl/tcg_back.sv
// back end: ones-complement accumulator and result register
`timescale 1ns / 1ps
`default_nettype none

module tcg_back
	import tcg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire tcg_entry_t  head,
	input  wire logic        q_empty,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      checksum,
	output logic             status
);

	logic [15:0] running_sum_q;
	logic        out_valid_q;
	logic [15:0] checksum_q;
	logic        status_q;

	logic        slot_free;
	logic        finish;
	logic [16:0] add17;
	logic [15:0] new_sum;
	logic [15:0] cpl;

	assign slot_free = !out_valid_q || out_ready;
	// only a closing word needs room in the result register
	assign pop    = !q_empty && (!head.last || slot_free);
	assign finish = pop && head.last && !head.start;

	always_comb begin
		add17 = {1'b0, running_sum_q} + {1'b0, head.value};
		if (head.start)
			new_sum = head.value;
		else
			new_sum = add17[15:0] + {15'b0, add17[16]};
		cpl = ~new_sum;
		if (cpl == '0)
			cpl = SUM_ALL_ONES;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (pop)
				running_sum_q <= finish ? '0 : new_sum;
			if (finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			checksum_q <= head.err ? '0 : cpl;
			status_q   <= head.err;
		end
	end

	assign out_valid = out_valid_q;
	assign checksum  = checksum_q;
	assign status    = status_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q) |-> checksum_q == '0)
		else $error("error result with nonzero checksum");

	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !status_q) |-> checksum_q != '0)
		else $error("good result with zero checksum");

	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !finish)
		else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// File: hdl/transport_checksum_generator_core.sv
// Transport checksum generator: TCP/UDP checksum over IPv4 pseudo-header and segment.
// Input stream s_axis: tuser = 0 marks a start word carrying the pseudo-header
// (addresses, protocol, segment length); tuser = 1 marks a segment data word, two
// bytes with the first byte high. tlast flags the final data word, whose byte_count
// may be 1 (low byte padded with zero). The checksum field of the header (word 3
// for UDP, word 8 for TCP) is summed as zero.
// Output stream m_axis: one word per segment, on its last data word: the
// complemented ones-complement sum (0 sent as 0xffff) with tuser = 0, or checksum 0
// with tuser = 1 when the protocol was neither TCP nor UDP or no start word came.
// Throughput is one word per cycle on both start and data words while the queue has
// room; the front end folds the six pseudo-header words and masks data, the back end
// does one 16-bit end-around add per word. The last word passes through the queue,
// then the back end registers the result. A small word queue sits between front and
// back, so a stalled m_axis only holds back the input once the queue has filled; the
// result register keeps its word until m_axis_tready. Reset clears the queue, the
// packet state and the output valid; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module transport_checksum_generator_core
	import tcg_pkg::*;
#(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// src_addr[31:0], dst_addr[63:32], protocol[71:64], seg_length[87:72],
	// data_word[103:88], byte_count[105:104], zero fill[111:106]
	input  wire logic [111:0] s_axis_tdata,
	// kind
	input  wire logic         s_axis_tuser,
	input  wire logic         s_axis_tlast,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// checksum[15:0]
	output logic [15:0]       m_axis_tdata,
	// status
	output logic              m_axis_tuser
);

	tcg_entry_t wr_entry;
	tcg_entry_t head;
	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_empty;

	tcg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.kind       (s_axis_tuser),
		.src_addr   (s_axis_tdata[31:0]),
		.dst_addr   (s_axis_tdata[63:32]),
		.protocol   (s_axis_tdata[71:64]),
		.seg_length (s_axis_tdata[87:72]),
		.data_word  (s_axis_tdata[103:88]),
		.byte_count (s_axis_tdata[105:104]),
		.last       (s_axis_tlast),
		.q_full     (q_full),
		.push       (push),
		.entry      (wr_entry)
	);

	tcg_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (q_full),
		.pop      (pop),
		.rd_entry (head),
		.empty    (q_empty)
	);

	tcg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.checksum  (m_axis_tdata),
		.status    (m_axis_tuser)
	);

endmodule

`default_nettype wire
